// ----- src/bgd_pkg.sv -----
// shared types, constants and helpers for the button gesture detector
package bgd_pkg;

    localparam int NUM_CONTROLLERS_DEF = 4;
    localparam int NUM_BUTTONS         = 3;
    localparam int MAX_EVENTS          = 2 * NUM_BUTTONS;
    localparam int CNT_W               = $clog2(MAX_EVENTS + 1);
    localparam int CTRL_W              = 2;
    localparam int TIME_W              = 32;
    localparam int CFG_W               = 16;
    localparam int CFG_IDX_W           = 1;

    localparam logic [CFG_W-1:0] CLICK_MAX_RESET = 16'd300;
    localparam logic [CFG_W-1:0] LONG_MIN_RESET  = 16'd1000;

    // item opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // event kinds
    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_CLICK   = 2'd2;
    localparam logic [1:0] KIND_LONG    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CLICK_MAX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN  = 1'd1;

    typedef struct packed {
        logic              opcode;
        logic [CTRL_W-1:0] controller_index;
        logic [TIME_W-1:0] current_time;
        logic              ok_level;
        logic              left_level;
        logic              right_level;
    } item_t;

    typedef struct packed {
        logic [CTRL_W-1:0] event_controller;
        logic [1:0]        button_id;
        logic [1:0]        event_kind;
        logic              last_event;
    } result_t;

    typedef struct packed {
        logic              held;
        logic              long_fired;
        logic [TIME_W-1:0] start;
    } btn_state_t;

    typedef btn_state_t [NUM_BUTTONS-1:0] row_t;

    typedef struct packed {
        result_t [MAX_EVENTS-1:0] ev;
        logic [CNT_W-1:0]         count;
    } ev_batch_t;

    function automatic result_t make_event(logic [CTRL_W-1:0] ctrl, logic [1:0] btn,
                                           logic [1:0] kind);
        result_t r;
        r.event_controller = ctrl;
        r.button_id        = btn;
        r.event_kind       = kind;
        r.last_event       = 1'b0;
        return r;
    endfunction

endpackage

// ----- src/button_gesture_detector.sv -----
// top level: input register, per-controller button state, config and result buffer
//
//  channel   | signals                              | beat
//  ----------+--------------------------------------+--------------------------------
//  item      | item_valid, item_ready, item         | one sample or clear command
//  result    | result_valid, result_ready, result   | one gesture event
//  config    | cfg_we, cfg_index, cfg_data          | one register write, no wait
//
// an accepted item is held in the input register, then its events load into the result
// buffer, whose head drives the result channel
// an item holding k events (k = 0..6) sends k beats on the result channel; items with
// no event, clear commands and out-of-range controllers retire without the buffer
// state is written as the item leaves the input register, so back-to-back items on the
// same controller see each other's updates
// reset clears all button state and loads the default limits (300 ms, 1000 ms)
// a stalled result holds the buffer; an item with events then waits in the input register
module button_gesture_detector
    import bgd_pkg::*;
#(
    parameter int NUM_CONTROLLERS = NUM_CONTROLLERS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int ROW_W = (NUM_CONTROLLERS > 1) ? $clog2(NUM_CONTROLLERS) : 1;

    // config registers
    logic [CFG_W-1:0] click_max_reg;
    logic [CFG_W-1:0] long_min_reg;

    // input register
    logic  held_valid_reg;
    item_t held_item_reg;

    // per-controller state, one row of three buttons each
    row_t  rows_reg [NUM_CONTROLLERS];

    logic             in_range;
    logic [ROW_W-1:0] row_idx;
    row_t             row_cur;
    row_t             row_next;
    ev_batch_t        batch;
    logic             has_events;
    logic             q_can_load;
    logic             q_load;
    logic             item_move;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            click_max_reg <= CLICK_MAX_RESET;
            long_min_reg  <= LONG_MIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CLICK_MAX: click_max_reg <= cfg_data;
                CFG_LONG_MIN:  long_min_reg  <= cfg_data;
            endcase
        end
    end

    // controller decode, out-of-range items pass through untouched
    assign in_range = int'(held_item_reg.controller_index) < NUM_CONTROLLERS;
    assign row_idx  = ROW_W'(held_item_reg.controller_index);
    assign row_cur  = in_range ? rows_reg[row_idx] : '0;

    bgd_event_gen u_gen (
        .item              (held_item_reg),
        .row               (row_cur),
        .click_max_ms      (click_max_reg),
        .long_press_min_ms (long_min_reg),
        .batch             (batch),
        .row_next          (row_next)
    );

    // an item only waits for the buffer when it has something to say
    assign has_events = in_range && (batch.count != '0);
    assign item_move  = held_valid_reg && (!has_events || q_can_load);
    assign q_load     = held_valid_reg && has_events && q_can_load;
    assign item_ready = !held_valid_reg || item_move;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            held_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            held_item_reg <= item;
        end
    end

    // state update as the item retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_CONTROLLERS; c++)
            begin
                rows_reg[c] <= '0;
            end
        end
        else if (item_move && in_range)
        begin
            rows_reg[row_idx] <= row_next;
        end
    end

    bgd_event_queue u_queue (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (q_load),
        .batch        (batch),
        .can_load     (q_can_load),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // empty input register always takes a beat
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !held_valid_reg |-> item_ready)
        else $error("input register empty but item_ready low");

    // taking the last event with nothing loading leaves the result channel idle
    a_drain_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_ready && result.last_event && !q_load) |=> !result_valid)
        else $error("result still valid after last event");

    // a retired clear command leaves its controller's row at zero
    a_clear_zeroes_row: assert property (@(posedge clk) disable iff (!rst_n)
        (item_move && in_range && held_item_reg.opcode == OP_CLEAR)
        |=> rows_reg[$past(row_idx)] == '0)
        else $error("clear command left button state behind");

    // out-of-range controllers never produce events
    a_range_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        (held_valid_reg && !in_range) |-> !q_load)
        else $error("event loaded for out-of-range controller");

endmodule

// ----- src/bgd_event_gen.sv -----
// per-item edge and hold-time decode for one controller's three buttons
module bgd_event_gen
    import bgd_pkg::*;
(
    input  item_t            item,
    input  row_t             row,
    input  logic [CFG_W-1:0] click_max_ms,
    input  logic [CFG_W-1:0] long_press_min_ms,
    output ev_batch_t        batch,
    output row_t             row_next
);

    always_comb
    begin
        logic [NUM_BUTTONS-1:0] lvl;
        logic [CNT_W-1:0]       n;
        logic [TIME_W-1:0]      dur;
        lvl      = {item.right_level, item.left_level, item.ok_level};
        n        = '0;
        dur      = '0;
        batch    = '0;
        row_next = row;
        if (item.opcode == OP_CLEAR)
        begin
            row_next = '0;
        end
        else
        begin
            for (int b = 0; b < NUM_BUTTONS; b++)
            begin
                dur = item.current_time - row[b].start;
                if (lvl[b] && !row[b].held)
                begin
                    row_next[b].held       = 1'b1;
                    row_next[b].start      = item.current_time;
                    row_next[b].long_fired = 1'b0;
                    batch.ev[n] = make_event(item.controller_index, 2'(b), KIND_PRESS);
                    n = n + 1'b1;
                end
                else if (!lvl[b] && row[b].held)
                begin
                    row_next[b].held       = 1'b0;
                    row_next[b].long_fired = 1'b0;
                    batch.ev[n] = make_event(item.controller_index, 2'(b), KIND_RELEASE);
                    n = n + 1'b1;
                    if (!row[b].long_fired && dur <= {{(TIME_W-CFG_W){1'b0}}, click_max_ms})
                    begin
                        batch.ev[n] = make_event(item.controller_index, 2'(b), KIND_CLICK);
                        n = n + 1'b1;
                    end
                end
                else if (lvl[b] && row[b].held && !row[b].long_fired &&
                         dur >= {{(TIME_W-CFG_W){1'b0}}, long_press_min_ms})
                begin
                    row_next[b].long_fired = 1'b1;
                    batch.ev[n] = make_event(item.controller_index, 2'(b), KIND_LONG);
                    n = n + 1'b1;
                end
            end
        end
        batch.count = n;
        // tag the final event of this item
        if (n != '0)
        begin
            batch.ev[n - 1'b1].last_event = 1'b1;
        end
    end

endmodule

// ----- src/bgd_event_queue.sv -----
// result buffer that drains one item's events one beat at a time
module bgd_event_queue
    import bgd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  ev_batch_t batch,
    output logic      can_load,
    output logic      result_valid,
    input  logic      result_ready,
    output result_t   result
);

    result_t [MAX_EVENTS-1:0] ev_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     take;

    assign take         = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = ev_reg[0];
    // free now, or the last buffered beat leaves this cycle
    assign can_load     = (count_reg == '0) || (count_reg == CNT_W'(1) && result_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (load)
        begin
            count_reg <= batch.count;
        end
        else if (take)
        begin
            count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ev_reg <= batch.ev;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_EVENTS - 1; i++)
            begin
                ev_reg[i] <= ev_reg[i + 1];
            end
        end
    end

endmodule
